[src/gltm_pkg.sv]
// gltm_pkg: shared constants for the global luminance tone mapper.
// Luminance weights, fixed-point widths and the register reset value.
// No dependencies.
package gltm_pkg;

  // Rec. 709 luminance weights, Q0.16, sum is exactly 1.0
  localparam int          WEIGHT_BITS  = 16;
  localparam logic [15:0] WEIGHT_RED   = 16'd13938;
  localparam logic [15:0] WEIGHT_GREEN = 16'd46868;
  localparam logic [15:0] WEIGHT_BLUE  = 16'd4730;

  localparam int          GAIN_BITS    = 24;
  localparam logic [23:0] GAIN_RESET   = 24'd65536;

  localparam int          SCALE_BITS   = 32;   // scale factor, Q16.16
  localparam int          PROD_BITS    = 40;   // channel times scale, Q.16
  localparam int          OUT_SHIFT    = 16;
  localparam int          OUT_BITS     = 17;
  localparam logic [16:0] OUT_ONE      = 17'd65536;

endpackage

[src/global_luminance_tone_map.sv]
// Global luminance tone mapper: bit-serial sequencer, multipliers and divider.
// Depends on gltm_pkg.
//
// Usage: the host streams each frame twice over the in_ channel. Words with
// in_mode low are measured: their luminance updates the running peak, and
// in_frame_start restarts the peak from that word. No result is produced.
// Words with in_mode high are mapped and give one out_ word with the three
// tone mapped channels in Q1.16, clamped to 1.0. cfg_we writes display_gain
// (Q8.16) in the same cycle; write it only while the block is idle.
// Sequence, all bit-serial with one bit per cycle: a measure word runs the
//   luminance pass and updates the peak, then in_ready returns; no output.
//   A map word runs the luminance pass; with a nonzero peak it then squares
//   the peak, multiplies it by 1.0 + y and runs the restoring divider. Then
//   it multiplies the channels by the scale (1.0 for a zero peak), saturates,
//   multiplies by the gain and loads the output register.
// One word is in flight at a time; the next is taken in the cycle after the
// previous finishes. The output register holds a finished word while the
// receiver stalls, and a new input word is accepted meanwhile; a second
// mapped result then waits in its last step until the output register frees.
// Reset (rst_n low, synchronous) clears the peak to zero, sets the gain to
// 1.0 and drops out_valid.
module global_luminance_tone_map
  import gltm_pkg::*;
#(
  parameter int CHANNEL_BITS  = 24,
  parameter int FRACTION_BITS = 20
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [GAIN_BITS-1:0]    cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_mode,
  input  logic                    in_frame_start,
  input  logic [CHANNEL_BITS-1:0] in_red_in,
  input  logic [CHANNEL_BITS-1:0] in_green_in,
  input  logic [CHANNEL_BITS-1:0] in_blue_in,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [OUT_BITS-1:0]     out_red_out,
  output logic [OUT_BITS-1:0]     out_green_out,
  output logic [OUT_BITS-1:0]     out_blue_out
);

  localparam int CB   = CHANNEL_BITS;
  localparam int FB   = FRACTION_BITS;
  localparam int MX   = (CB > FB) ? CB : FB;
  localparam int EW   = MX + 1;                       // 1.0 + y
  localparam int P2W  = 2 * CB;                       // peak squared
  localparam int DW   = P2W + EW;                     // divisor
  localparam int CF   = CB + FB;
  localparam int AW   = ((P2W > CF) ? P2W : CF) + 1;  // numerator before shift
  localparam int NW   = AW + OUT_SHIFT + FB;          // divider iterations
  localparam int LW   = CB + WEIGHT_BITS + 2;
  localparam int L1W  = CB + SCALE_BITS;
  localparam int L2W  = PROD_BITS + GAIN_BITS;
  localparam int LAW  = (L1W > L2W) ? L1W : L2W;
  localparam int MPA  = (EW > SCALE_BITS) ? EW : SCALE_BITS;
  localparam int MPW  = (MPA > GAIN_BITS) ? MPA : GAIN_BITS;
  localparam int CNTW = $clog2(NW);
  localparam int WIW  = $clog2(WEIGHT_BITS);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LUM   = 4'd1;
  localparam logic [3:0] S_EVAL  = 4'd2;
  localparam logic [3:0] S_SQR   = 4'd3;
  localparam logic [3:0] S_DEN   = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_MUL_S = 4'd6;
  localparam logic [3:0] S_SAT   = 4'd7;
  localparam logic [3:0] S_MUL_G = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0]           state_r, state_nxt;
  logic [CNTW-1:0]      cnt_r, cnt_nxt;
  logic                 mode_r, mode_nxt;
  logic                 start_r, start_nxt;
  logic [CB-1:0]        ch_r [3];
  logic [CB-1:0]        ch_nxt [3];
  logic [LW-1:0]        lum_r, lum_nxt;
  logic [CB-1:0]        y_r, y_nxt;
  logic [CB-1:0]        peak_r, peak_nxt;
  logic [GAIN_BITS-1:0] gain_r, gain_nxt;
  logic [MPW-1:0]       mpl_r, mpl_nxt;
  logic [DW-1:0]        mul_r, mul_nxt;
  logic [P2W-1:0]       p2_r, p2_nxt;
  logic [AW-1:0]        num_r, num_nxt;
  logic [DW-1:0]        rem_r, rem_nxt;
  logic [SCALE_BITS-1:0] q_r, q_nxt;
  logic                 sat_r, sat_nxt;
  logic [LAW-1:0]       lane_r [3];
  logic [LAW-1:0]       lane_nxt [3];
  logic [PROD_BITS-1:0] t_r [3];
  logic [PROD_BITS-1:0] t_nxt [3];
  logic [OUT_BITS-1:0]  out_r [3];
  logic [OUT_BITS-1:0]  out_nxt [3];
  logic                 out_valid_r, out_valid_nxt;

  // datapath terms
  logic                 mbit, cnt_last;
  logic [WIW-1:0]       wi;
  logic [LW-1:0]        lum_step;
  logic [CB-1:0]        y_val;
  logic [DW-1:0]        mul_mcand, mul_step;
  logic [DW:0]          rem_sh, rem_dif;
  logic                 qbit;
  logic [DW-1:0]        rem_new;
  logic [SCALE_BITS-1:0] q_new, s_div;
  logic                 sat_new;
  logic [EW-1:0]        e_val;
  logic [AW-1:0]        a_val;
  logic [LAW-1:0]       lane_mc [3];
  logic [LAW-1:0]       lane_step [3];
  logic [LAW-1:0]       t_sh [3];
  logic [PROD_BITS-1:0] t_val [3];
  logic [LAW-1:0]       o_sh [3];
  logic [OUT_BITS-1:0]  o_val [3];

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_red_out   = out_r[0];
  assign out_green_out = out_r[1];
  assign out_blue_out  = out_r[2];

  assign mbit     = mpl_r[MPW-1];
  assign cnt_last = (cnt_r == '0);
  assign wi       = cnt_r[WIW-1:0];

  // luminance, MSB-first over the weight bits
  assign lum_step = (lum_r << 1)
                  + (WEIGHT_RED[wi]   ? LW'(ch_r[0]) : '0)
                  + (WEIGHT_GREEN[wi] ? LW'(ch_r[1]) : '0)
                  + (WEIGHT_BLUE[wi]  ? LW'(ch_r[2]) : '0);
  assign y_val = lum_r[WEIGHT_BITS +: CB];

  // peak squared, then times (1.0 + y)
  assign mul_mcand = (state_r == S_SQR) ? DW'(peak_r) : DW'(p2_r);
  assign mul_step  = (mul_r << 1) + (mbit ? mul_mcand : '0);

  assign e_val = (EW'(1) << FB) + EW'(y_r);
  assign a_val = AW'(p2_r) + (AW'(y_r) << FB);

  // restoring divider; numerator shifts out MSB first, zeros after it empties
  assign rem_sh  = {rem_r, num_r[AW-1]};
  assign rem_dif = rem_sh - {1'b0, mul_r};
  assign qbit    = (rem_sh >= {1'b0, mul_r});
  assign rem_new = qbit ? rem_dif[DW-1:0] : rem_sh[DW-1:0];
  assign q_new   = {q_r[SCALE_BITS-2:0], qbit};
  // a quotient bit at weight 2^32 or above means the scale saturates
  assign sat_new = sat_r | (qbit && (cnt_r >= CNTW'(SCALE_BITS)));
  assign s_div   = sat_new ? '1 : q_new;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lane_mc[k]   = (state_r == S_MUL_S) ? LAW'(ch_r[k]) : LAW'(t_r[k]);
      lane_step[k] = (lane_r[k] << 1) + (mbit ? lane_mc[k] : '0);
      t_sh[k]      = lane_r[k] >> FB;
      t_val[k]     = (|t_sh[k][LAW-1:PROD_BITS]) ? '1 : t_sh[k][PROD_BITS-1:0];
      o_sh[k]      = lane_r[k] >> OUT_SHIFT;
      o_val[k]     = (o_sh[k] > LAW'(OUT_ONE)) ? OUT_ONE : o_sh[k][OUT_BITS-1:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    mode_nxt      = mode_r;
    start_nxt     = start_r;
    ch_nxt        = ch_r;
    lum_nxt       = lum_r;
    y_nxt         = y_r;
    peak_nxt      = peak_r;
    gain_nxt      = cfg_we ? cfg_wdata : gain_r;
    mpl_nxt       = mpl_r;
    mul_nxt       = mul_r;
    p2_nxt        = p2_r;
    num_nxt       = num_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    sat_nxt       = sat_r;
    lane_nxt      = lane_r;
    t_nxt         = t_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt  = in_mode;
          start_nxt = in_frame_start;
          ch_nxt[0] = in_red_in;
          ch_nxt[1] = in_green_in;
          ch_nxt[2] = in_blue_in;
          lum_nxt   = '0;
          cnt_nxt   = CNTW'(WEIGHT_BITS - 1);
          state_nxt = S_LUM;
        end
      end
      S_LUM: begin
        lum_nxt = lum_step;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_last) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        y_nxt = y_val;
        if (!mode_r) begin
          if (start_r || (y_val > peak_r)) begin
            peak_nxt = y_val;
          end
          state_nxt = S_IDLE;
        end else if (peak_r == '0) begin
          // zero peak: scale is exactly 1.0
          mpl_nxt = MPW'(SCALE_BITS'(OUT_ONE)) << (MPW - SCALE_BITS);
          for (int k = 0; k < 3; k++) lane_nxt[k] = '0;
          cnt_nxt   = CNTW'(SCALE_BITS - 1);
          state_nxt = S_MUL_S;
        end else begin
          mpl_nxt   = MPW'(peak_r) << (MPW - CB);
          mul_nxt   = '0;
          cnt_nxt   = CNTW'(CB - 1);
          state_nxt = S_SQR;
        end
      end
      S_SQR: begin
        mul_nxt = mul_step;
        mpl_nxt = mpl_r << 1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_last) begin
          p2_nxt    = mul_step[P2W-1:0];
          mul_nxt   = '0;
          mpl_nxt   = MPW'(e_val) << (MPW - EW);
          cnt_nxt   = CNTW'(EW - 1);
          state_nxt = S_DEN;
        end
      end
      S_DEN: begin
        mul_nxt = mul_step;
        mpl_nxt = mpl_r << 1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_last) begin
          num_nxt   = a_val;
          rem_nxt   = '0;
          q_nxt     = '0;
          sat_nxt   = 1'b0;
          cnt_nxt   = CNTW'(NW - 1);
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        rem_nxt = rem_new;
        q_nxt   = q_new;
        sat_nxt = sat_new;
        num_nxt = num_r << 1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_last) begin
          mpl_nxt = MPW'(s_div) << (MPW - SCALE_BITS);
          for (int k = 0; k < 3; k++) lane_nxt[k] = '0;
          cnt_nxt   = CNTW'(SCALE_BITS - 1);
          state_nxt = S_MUL_S;
        end
      end
      S_MUL_S: begin
        lane_nxt = lane_step;
        mpl_nxt  = mpl_r << 1;
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_last) begin
          state_nxt = S_SAT;
        end
      end
      S_SAT: begin
        t_nxt = t_val;
        for (int k = 0; k < 3; k++) lane_nxt[k] = '0;
        mpl_nxt   = MPW'(gain_r) << (MPW - GAIN_BITS);
        cnt_nxt   = CNTW'(GAIN_BITS - 1);
        state_nxt = S_MUL_G;
      end
      S_MUL_G: begin
        lane_nxt = lane_step;
        mpl_nxt  = mpl_r << 1;
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_last) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // wait here while the output register still holds an untaken word
        if (!out_valid_r || out_ready) begin
          out_nxt       = o_val;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      peak_r      <= '0;
      gain_r      <= GAIN_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      peak_r      <= peak_nxt;
      gain_r      <= gain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    mode_r  <= mode_nxt;
    start_r <= start_nxt;
    ch_r    <= ch_nxt;
    lum_r   <= lum_nxt;
    y_r     <= y_nxt;
    mpl_r   <= mpl_nxt;
    mul_r   <= mul_nxt;
    p2_r    <= p2_nxt;
    num_r   <= num_nxt;
    rem_r   <= rem_nxt;
    q_r     <= q_nxt;
    sat_r   <= sat_nxt;
    lane_r  <= lane_nxt;
    t_r     <= t_nxt;
    out_r   <= out_nxt;
  end

  a_accept_starts_lum: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_LUM))
    else $error("accepted word did not start the luminance pass");

  a_peak_only_in_measure: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r != S_EVAL) || mode_r) |=> $stable(peak_r))
    else $error("peak changed outside a measure word");

  a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < mul_r))
    else $error("divider remainder not below divisor");

  a_out_only_map: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) |-> mode_r)
    else $error("measure word reached the output step");

endmodule
